FILE: hw/rtl/wpj_pkg.sv
// Package for the whitening projection unit: word types, lane result struct
// and the fixed Q2.14 coefficient table. Depends on nothing.
package wpj_pkg;

   // Number of vector elements and of output lanes.
   localparam int VectorLen = 7;
   // Fraction bits of the coefficients; the sum is scaled down by this much.
   localparam int CoefFrac = 14;
   // Product and accumulator widths: 16x16 signed products, seven of them summed.
   localparam int ProdWidth = 32;
   localparam int SumWidth = 35;
   // Width of the rounded sum before saturation.
   localparam int RoundWidth = SumWidth - CoefFrac;

   typedef logic signed [15:0] sample_type;
   typedef logic signed [15:0] coef_type;
   typedef sample_type sample_vec_type [VectorLen];
   typedef coef_type coef_row_type [VectorLen];

   // What one lane hands to the merge stage.
   typedef struct packed {
      sample_type value;
      logic clip;
   } lane_result_type;

   typedef lane_result_type lane_vec_type [VectorLen];

   // Eigenvector rows already divided by the root of their eigenvalue, Q2.14.
   localparam coef_row_type WhitenCoef [VectorLen] = '{
      '{ 16'sd2365,   16'sd3096,   16'sd3462,   16'sd3575,
         16'sd3462,   16'sd3096,   16'sd2365 },
      '{ -16'sd7094,  -16'sd6192,  -16'sd3462,  16'sd0,
         16'sd3462,   16'sd6192,   16'sd7094 },
      '{ 16'sd11320,  16'sd2469,   -16'sd5522,  -16'sd8556,
         -16'sd5522,  16'sd2469,   16'sd11320 },
      '{ -16'sd12351, 16'sd8085,   16'sd10847,  16'sd1,
         -16'sd10847, -16'sd8085,  16'sd12351 },
      '{ 16'sd9836,   -16'sd17174, 16'sd960,    16'sd14877,
         16'sd960,    -16'sd17174, 16'sd9836 },
      '{ -16'sd5658,  16'sd17289,  -16'sd19330, 16'sd1,
         16'sd19330,  -16'sd17289, 16'sd5658 },
      '{ 16'sd2093,   -16'sd9593,  16'sd21446,  -16'sd27682,
         16'sd21446,  -16'sd9593,  16'sd2093 }
   };

endpackage

FILE: hw/rtl/wpj_lane.sv
// One projection lane: seven registered products, a registered sum, then rounding and
// saturation of that sum. Depends on wpj_pkg.
module wpj_lane (
   input  logic                     clock,
   input  wpj_pkg::sample_vec_type  samples,
   input  wpj_pkg::coef_row_type    lane_coef,
   output wpj_pkg::lane_result_type result
);
   import wpj_pkg::*;

   logic signed [ProdWidth-1:0]  prod_ff [VectorLen];
   logic signed [ProdWidth-1:0]  prod_in [VectorLen];
   logic signed [SumWidth-1:0]   sum_ff;
   logic signed [SumWidth-1:0]   sum_in;
   logic signed [RoundWidth-1:0] rounded;

   // Multiply each element by its coefficient; the products are exact.
   always_comb begin
      for (int j = 0; j < VectorLen; j++) begin
         prod_in[j] = ProdWidth'(samples[j] * lane_coef[j]);
      end
   end

   // Sum the seven products and add half an output step for round half up.
   always_comb begin
      sum_in = SumWidth'(1) <<< (CoefFrac - 1);
      for (int j = 0; j < VectorLen; j++) begin
         sum_in = sum_in + SumWidth'(prod_ff[j]);
      end
   end

   // Pipeline registers; payload only, no reset needed.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff <= sum_in;
   end

   // Drop the fraction bits (floor) and saturate to the 16-bit output range.
   assign rounded = sum_ff[SumWidth-1:CoefFrac];

   always_comb begin
      priority if (rounded > RoundWidth'(32767)) begin
         result.value = 16'sh7fff;
         result.clip = 1'b1;
      end else if (rounded < -RoundWidth'(32768)) begin
         result.value = 16'sh8000;
         result.clip = 1'b1;
      end else begin
         result.value = rounded[15:0];
         result.clip = 1'b0;
      end
   end

endmodule

FILE: hw/rtl/wpj_merge.sv
// Merge stage: registers the lane outputs into one result word, folds the
// lane saturation flags together and drives the strobe. Depends on wpj_pkg.
module wpj_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  lanes_valid,
   input  wpj_pkg::lane_vec_type lanes,
   output logic                  rsp_valid,
   output wpj_pkg::sample_vec_type factors,
   output logic                  clipped
);
   import wpj_pkg::*;

   logic           valid_ff;
   logic           clip_ff;
   logic           clip_in;
   sample_vec_type factor_ff;

   // Any lane that saturated marks the whole word.
   always_comb begin
      clip_in = 1'b0;
      for (int i = 0; i < VectorLen; i++) begin
         clip_in = clip_in | lanes[i].clip;
      end
   end

   // Result strobe is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= lanes_valid;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      for (int i = 0; i < VectorLen; i++) begin
         factor_ff[i] <= lanes[i].value;
      end
      clip_ff <= clip_in;
   end

   assign rsp_valid = valid_ff;
   assign factors = factor_ff;
   assign clipped = clip_ff;

endmodule

FILE: hw/rtl/whitening_projection_7_unit.sv
// Whitening projection unit: seven sample elements in, seven whitened
// factors out. Top level; depends on wpj_pkg, wpj_lane and wpj_merge.
//
// Usage:
//   A word is taken on the request ports at a rising edge where start is
//   high and busy is low. busy is never raised, so a new word may be
//   offered in every cycle: one word per cycle sustained.
//   Each word gives exactly one result word on the rsp_ ports, shown for one
//   cycle with rsp_valid high, after it has passed the input register,
//   product register, sum register and output register in that order.
//   Seven lanes, one per eigenvector row, each with seven multipliers, work
//   side by side; the merge stage registers their outputs and raises
//   rsp_clipped if any factor saturated.
//   Results cannot be held off by the receiver; a word not taken in its
//   cycle is gone. Reset clears the valid pipeline, so no result word comes
//   out for words in flight at reset. No configuration is needed.
module whitening_projection_7_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wpj_pkg::sample_type req_sample_0,
   input  wpj_pkg::sample_type req_sample_1,
   input  wpj_pkg::sample_type req_sample_2,
   input  wpj_pkg::sample_type req_sample_3,
   input  wpj_pkg::sample_type req_sample_4,
   input  wpj_pkg::sample_type req_sample_5,
   input  wpj_pkg::sample_type req_sample_6,
   output logic              rsp_valid,
   output wpj_pkg::sample_type rsp_factor_0,
   output wpj_pkg::sample_type rsp_factor_1,
   output wpj_pkg::sample_type rsp_factor_2,
   output wpj_pkg::sample_type rsp_factor_3,
   output wpj_pkg::sample_type rsp_factor_4,
   output wpj_pkg::sample_type rsp_factor_5,
   output wpj_pkg::sample_type rsp_factor_6,
   output logic              rsp_clipped
);
   import wpj_pkg::*;

   logic           accept;
   logic [2:0]     valid_ff;
   logic [2:0]     valid_in;
   sample_vec_type sample_ff;
   lane_vec_type   lane_out;
   sample_vec_type factors;

   // The pipeline never stalls, so a word is taken whenever start is high.
   assign busy = 1'b0;
   assign accept = start & ~busy;

   // Valid bits follow each word through input, product and sum registers.
   assign valid_in = {valid_ff[1:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Input register, loaded on accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff[0] <= req_sample_0;
         sample_ff[1] <= req_sample_1;
         sample_ff[2] <= req_sample_2;
         sample_ff[3] <= req_sample_3;
         sample_ff[4] <= req_sample_4;
         sample_ff[5] <= req_sample_5;
         sample_ff[6] <= req_sample_6;
      end
   end

   // One lane per eigenvector row.
   for (genvar i = 0; i < VectorLen; i++) begin : g_lane
      wpj_lane u_lane (
         .clock     (clock),
         .samples   (sample_ff),
         .lane_coef (WhitenCoef[i]),
         .result    (lane_out[i])
      );
   end

   // Combine lane outputs into the result word.
   wpj_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .lanes_valid (valid_ff[2]),
      .lanes       (lane_out),
      .rsp_valid   (rsp_valid),
      .factors     (factors),
      .clipped     (rsp_clipped)
   );

   assign rsp_factor_0 = factors[0];
   assign rsp_factor_1 = factors[1];
   assign rsp_factor_2 = factors[2];
   assign rsp_factor_3 = factors[3];
   assign rsp_factor_4 = factors[4];
   assign rsp_factor_5 = factors[5];
   assign rsp_factor_6 = factors[6];

endmodule

FILE: tb/whitening_projection_7_unit_test.sv
`timescale 1ns / 1ps
// Self-checking test of the whitening projection unit: each sample word is
// predicted here with the fixed Q2.14 table and compared against rsp_ words.
// Depends on wpj_pkg and whitening_projection_7_unit.
module whitening_projection_7_unit_test;
   import wpj_pkg::*;

   localparam int NumLanes = 7;
   localparam int RoundBit = 8192;
   localparam longint FactorMax = 32767;
   localparam longint FactorMin = -32768;
   localparam int RandomWords = 1600;
   localparam int BurstWords = 60;
   localparam int DrainCycles = 10;
   localparam int CycleLimit = 400000;

   // Whitening coefficients, one row per eigenvector, Q2.14.
   localparam int ProjectionCoef [NumLanes][NumLanes] = '{
      '{   2365,   3096,   3462,   3575,   3462,   3096,   2365 },
      '{  -7094,  -6192,  -3462,      0,   3462,   6192,   7094 },
      '{  11320,   2469,  -5522,  -8556,  -5522,   2469,  11320 },
      '{ -12351,   8085,  10847,      1, -10847,  -8085,  12351 },
      '{   9836, -17174,    960,  14877,    960, -17174,   9836 },
      '{  -5658,  17289, -19330,      1,  19330, -17289,   5658 },
      '{   2093,  -9593,  21446, -27682,  21446,  -9593,   2093 }
   };

   // Kinds of random sample words.
   typedef enum int {
      KIND_UNIFORM,
      KIND_SMALL,
      KIND_SATURATE
   } vector_kind_type;

   typedef struct packed {
      logic [NumLanes-1:0][15:0] factor;
      logic clipped;
   } whitened_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sample_type sample_drive [NumLanes] = '{default: 16'sd0};
   logic rsp_valid;
   sample_type factor_seen [NumLanes];
   logic rsp_clipped;

   whitened_word_type expected_factors [$];
   int error_count = 0;
   int cycle_count = 0;

   whitening_projection_7_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_sample_0(sample_drive[0]),
      .req_sample_1(sample_drive[1]),
      .req_sample_2(sample_drive[2]),
      .req_sample_3(sample_drive[3]),
      .req_sample_4(sample_drive[4]),
      .req_sample_5(sample_drive[5]),
      .req_sample_6(sample_drive[6]),
      .rsp_valid(rsp_valid),
      .rsp_factor_0(factor_seen[0]),
      .rsp_factor_1(factor_seen[1]),
      .rsp_factor_2(factor_seen[2]),
      .rsp_factor_3(factor_seen[3]),
      .rsp_factor_4(factor_seen[4]),
      .rsp_factor_5(factor_seen[5]),
      .rsp_factor_6(factor_seen[6]),
      .rsp_clipped(rsp_clipped)
   );

   always #6 clock = ~clock;

   // The run is cut off if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t: timeout, %0d words still expected", $time,
                  expected_factors.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Projects one sample word onto every row, rounds half up and saturates.
   function automatic whitened_word_type whiten_vector(input sample_type v [NumLanes]);
      whitened_word_type w;
      longint acc;
      longint rounded;
      w.clipped = 1'b0;
      for (int i = 0; i < NumLanes; i++) begin
         acc = 0;
         for (int j = 0; j < NumLanes; j++)
            acc += longint'(v[j]) * longint'(ProjectionCoef[i][j]);
         rounded = (acc + RoundBit) >>> CoefFrac;
         if (rounded > FactorMax) begin
            rounded = FactorMax;
            w.clipped = 1'b1;
         end else if (rounded < FactorMin) begin
            rounded = FactorMin;
            w.clipped = 1'b1;
         end
         w.factor[i] = rounded[15:0];
      end
      return w;
   endfunction

   // Offers one sample word and waits until it is taken.
   task automatic send_vector(input sample_type v [NumLanes]);
      @(negedge clock);
      for (int j = 0; j < NumLanes; j++)
         sample_drive[j] <= v[j];
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      expected_factors.push_back(whiten_vector(v));
   endtask

   // Holds start low for the given number of cycles.
   task automatic idle_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Most gaps are short, a few are long, half are absent.
   task automatic random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return;
      else if (r < 90)
         idle_cycles($urandom_range(1, 3));
      else
         idle_cycles($urandom_range(5, 40));
   endtask

   // Full-scale word whose signs follow one row, so that lane is driven hardest.
   function automatic void row_aligned(input int row, input bit negate,
                                       output sample_type v [NumLanes]);
      for (int j = 0; j < NumLanes; j++)
         v[j] = ((ProjectionCoef[row][j] >= 0) ^ negate) ? 16'sh7fff : 16'sh8000;
   endfunction

   // Extremes, rounding at exactly one half, impulses and saturation of lanes 4 to 6.
   task automatic test_directed_corners();
      sample_type v [NumLanes];
      v = '{default: 16'sd0};
      send_vector(v);
      v = '{default: 16'sh7fff};
      send_vector(v);
      v = '{default: 16'sh8000};
      send_vector(v);
      for (int p = 0; p < 2; p++) begin
         for (int j = 0; j < NumLanes; j++)
            v[j] = ((j % 2) == p) ? 16'sh7fff : 16'sh8000;
         send_vector(v);
         idle_cycles(1);
      end
      // The middle element alone lands exactly halfway in several lanes.
      v = '{default: 16'sd0};
      v[3] = 16'sd8192;
      send_vector(v);
      v[3] = -16'sd8192;
      send_vector(v);
      v[3] = 16'sd1;
      send_vector(v);
      v[3] = -16'sd1;
      send_vector(v);
      for (int j = 0; j < NumLanes; j++) begin
         v = '{default: 16'sd0};
         v[j] = 16'sh7fff;
         send_vector(v);
      end
      idle_cycles(3);
      for (int r = 4; r < NumLanes; r++) begin
         row_aligned(r, 1'b0, v);
         send_vector(v);
         row_aligned(r, 1'b1, v);
         send_vector(v);
      end
      idle_cycles(1);
   endtask

   // Builds one random sample word of the given kind.
   function automatic void random_vector(input vector_kind_type kind,
                                         output sample_type v [NumLanes]);
      unique case (kind)
         KIND_UNIFORM: begin
            for (int j = 0; j < NumLanes; j++)
               v[j] = sample_type'($urandom_range(0, 65535));
         end
         KIND_SMALL: begin
            for (int j = 0; j < NumLanes; j++)
               v[j] = sample_type'($urandom_range(0, 8192)) - 16'sd4096;
         end
         default: begin
            row_aligned($urandom_range(0, NumLanes - 1), $urandom_range(0, 1), v);
            // Back the aligned values off a little so some lanes just miss saturation.
            for (int j = 0; j < NumLanes; j++)
               if ($urandom_range(0, 3) == 0)
                  v[j] = v[j] >>> $urandom_range(1, 3);
         end
      endcase
   endfunction

   function automatic vector_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return KIND_UNIFORM;
      else if (r < 80)
         return KIND_SMALL;
      return KIND_SATURATE;
   endfunction

   // One word in every cycle with no gaps.
   task automatic test_full_rate_burst();
      sample_type v [NumLanes];
      for (int n = 0; n < BurstWords; n++) begin
         random_vector(pick_kind(), v);
         send_vector(v);
      end
      idle_cycles(2);
   endtask

   // Random words with random gaps between them.
   task automatic test_random_gaps();
      sample_type v [NumLanes];
      for (int n = 0; n < RandomWords - BurstWords; n++) begin
         random_vector(pick_kind(), v);
         send_vector(v);
         random_gap();
      end
      idle_cycles(1);
   endtask

   // Every result word is compared with the oldest prediction.
   always @(posedge clock) begin
      whitened_word_type w;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_factors.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            error_count++;
         end else begin
            w = expected_factors.pop_front();
            for (int i = 0; i < NumLanes; i++)
               if (factor_seen[i] !== w.factor[i]) begin
                  $display("%0t: factor_%0d expected %0d actual %0d", $time, i,
                           $signed(w.factor[i]), factor_seen[i]);
                  error_count++;
               end
            if (rsp_clipped !== w.clipped) begin
               $display("%0t: clipped expected %0b actual %0b", $time,
                        w.clipped, rsp_clipped);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_full_rate_burst();
      test_random_gaps();
      while (expected_factors.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
